// File: hdl/rsg_pkg.sv
`default_nettype none

package rsg_pkg;

  localparam int ANGLE_W = 16;
  localparam int DAC_W = 12;
  localparam int MAG_W = 11;
  localparam int FRAC_W = 6;
  localparam int BANK_AW = 8;
  localparam int DEG_AW = 7;
  localparam int DEG_W = 9;
  localparam int QUARTER_BANK = 129;
  localparam int DEGREE_DEPTH = 91;

  localparam logic [DAC_W-1:0] DAC_MID = 12'h7FF;
  localparam logic [DEG_W-1:0] DEG_QUARTER = 9'd90;
  localparam logic [DEG_W-1:0] DEG_HALF = 9'd180;
  localparam logic [DEG_W-1:0] DEG_THREE_QUARTER = 9'd270;
  localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;
  localparam logic [ANGLE_W-1:0] DEG_LIMIT = 16'd360;
  localparam logic [14:0] QUADRANT_SPAN = 15'h4000;
  localparam logic [ANGLE_W-1:0] COS_SHIFT = 16'h4000;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_DEGREE = 2'd2
  } req_code_t;

  typedef struct packed {
    logic                neg;
    logic                swap;
    logic [FRAC_W-1:0]   frac;
    logic [BANK_AW-1:0]  even_addr;
    logic [BANK_AW-1:0]  odd_addr;
    logic [DEG_AW-1:0]   deg_addr;
  } lane_t;

  typedef struct packed {
    logic  emit;
    logic  deg_mode;
    lane_t sin_lane;
    lane_t cos_lane;
  } look_t;

  typedef struct packed {
    logic [MAG_W-1:0] even;
    logic [MAG_W-1:0] odd;
    logic [MAG_W-1:0] deg;
  } rom_word_t;

  localparam logic [MAG_W-1:0] QUARTER_EVEN [QUARTER_BANK] = '{
    11'd0, 11'd25, 11'd50, 11'd75, 11'd100,
    11'd126, 11'd151, 11'd176, 11'd201, 11'd226,
    11'd251, 11'd275, 11'd300, 11'd325, 11'd350,
    11'd375, 11'd399, 11'd424, 11'd449, 11'd473,
    11'd497, 11'd522, 11'd546, 11'd570, 11'd594,
    11'd618, 11'd642, 11'd666, 11'd690, 11'd713,
    11'd737, 11'd760, 11'd783, 11'd807, 11'd830,
    11'd852, 11'd875, 11'd898, 11'd920, 11'd943,
    11'd965, 11'd987, 11'd1009, 11'd1031, 11'd1052,
    11'd1074, 11'd1095, 11'd1116, 11'd1137, 11'd1158,
    11'd1179, 11'd1199, 11'd1219, 11'd1239, 11'd1259,
    11'd1279, 11'd1299, 11'd1318, 11'd1337, 11'd1356,
    11'd1375, 11'd1393, 11'd1411, 11'd1430, 11'd1447,
    11'd1465, 11'd1483, 11'd1500, 11'd1517, 11'd1533,
    11'd1550, 11'd1566, 11'd1582, 11'd1598, 11'd1614,
    11'd1629, 11'd1644, 11'd1659, 11'd1674, 11'd1688,
    11'd1702, 11'd1716, 11'd1729, 11'd1743, 11'd1756,
    11'd1769, 11'd1781, 11'd1793, 11'd1805, 11'd1817,
    11'd1828, 11'd1840, 11'd1850, 11'd1861, 11'd1871,
    11'd1881, 11'd1891, 11'd1901, 11'd1910, 11'd1919,
    11'd1927, 11'd1936, 11'd1944, 11'd1951, 11'd1959,
    11'd1966, 11'd1973, 11'd1979, 11'd1986, 11'd1992,
    11'd1997, 11'd2003, 11'd2008, 11'd2012, 11'd2017,
    11'd2021, 11'd2025, 11'd2028, 11'd2032, 11'd2035,
    11'd2037, 11'd2039, 11'd2041, 11'd2043, 11'd2045,
    11'd2046, 11'd2046, 11'd2047, 11'd2047
  };

  localparam logic [MAG_W-1:0] QUARTER_ODD [QUARTER_BANK] = '{
    11'd13, 11'd38, 11'd63, 11'd88, 11'd113,
    11'd138, 11'd163, 11'd188, 11'd213, 11'd238,
    11'd263, 11'd288, 11'd313, 11'd338, 11'd362,
    11'd387, 11'd412, 11'd436, 11'd461, 11'd485,
    11'd510, 11'd534, 11'd558, 11'd582, 11'd606,
    11'd630, 11'd654, 11'd678, 11'd701, 11'd725,
    11'd748, 11'd772, 11'd795, 11'd818, 11'd841,
    11'd864, 11'd887, 11'd909, 11'd932, 11'd954,
    11'd976, 11'd998, 11'd1020, 11'd1042, 11'd1063,
    11'd1085, 11'd1106, 11'd1127, 11'd1148, 11'd1168,
    11'd1189, 11'd1209, 11'd1229, 11'd1249, 11'd1269,
    11'd1289, 11'd1308, 11'd1328, 11'd1347, 11'd1365,
    11'd1384, 11'd1402, 11'd1421, 11'd1439, 11'd1456,
    11'd1474, 11'd1491, 11'd1508, 11'd1525, 11'd1542,
    11'd1558, 11'd1574, 11'd1590, 11'd1606, 11'd1621,
    11'd1637, 11'd1652, 11'd1666, 11'd1681, 11'd1695,
    11'd1709, 11'd1723, 11'd1736, 11'd1749, 11'd1762,
    11'd1775, 11'd1787, 11'd1799, 11'd1811, 11'd1823,
    11'd1834, 11'd1845, 11'd1856, 11'd1866, 11'd1876,
    11'd1886, 11'd1896, 11'd1905, 11'd1914, 11'd1923,
    11'd1932, 11'd1940, 11'd1948, 11'd1955, 11'd1962,
    11'd1969, 11'd1976, 11'd1983, 11'd1989, 11'd1994,
    11'd2000, 11'd2005, 11'd2010, 11'd2015, 11'd2019,
    11'd2023, 11'd2027, 11'd2030, 11'd2033, 11'd2036,
    11'd2038, 11'd2040, 11'd2042, 11'd2044, 11'd2045,
    11'd2046, 11'd2047, 11'd2047, 11'd2047
  };

  localparam logic [MAG_W-1:0] DEGREE_TBL [DEGREE_DEPTH] = '{
    11'd0, 11'd36, 11'd71, 11'd107, 11'd143, 11'd178, 11'd214, 11'd249, 11'd285, 11'd320,
    11'd355, 11'd391, 11'd426, 11'd460, 11'd495, 11'd530, 11'd564, 11'd598, 11'd633,
    11'd666, 11'd700, 11'd734, 11'd767, 11'd800, 11'd833, 11'd865, 11'd897, 11'd929,
    11'd961, 11'd992, 11'd1024, 11'd1054, 11'd1085, 11'd1115, 11'd1145, 11'd1174,
    11'd1203, 11'd1232, 11'd1260, 11'd1288, 11'd1316, 11'd1343, 11'd1370, 11'd1396,
    11'd1422, 11'd1447, 11'd1472, 11'd1497, 11'd1521, 11'd1545, 11'd1568, 11'd1591,
    11'd1613, 11'd1635, 11'd1656, 11'd1677, 11'd1697, 11'd1717, 11'd1736, 11'd1755,
    11'd1773, 11'd1790, 11'd1807, 11'd1824, 11'd1840, 11'd1855, 11'd1870, 11'd1884,
    11'd1898, 11'd1911, 11'd1924, 11'd1935, 11'd1947, 11'd1958, 11'd1968, 11'd1977,
    11'd1986, 11'd1995, 11'd2002, 11'd2009, 11'd2016, 11'd2022, 11'd2027, 11'd2032,
    11'd2036, 11'd2039, 11'd2042, 11'd2044, 11'd2046, 11'd2047, 11'd2047
  };

  function automatic lane_t quarter_lane(logic [ANGLE_W-1:0] ang);
    lane_t      l;
    logic [14:0] off;
    logic [8:0]  n;
    l = '0;
    off = ang[14] ? (QUADRANT_SPAN - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    n = off[14:6];
    l.neg = ang[15];
    l.swap = n[0];
    l.frac = off[5:0];
    l.odd_addr = n[8:1];
    l.even_addr = n[8:1] + {7'd0, n[0]};
    return l;
  endfunction

  function automatic lane_t degree_lane(logic [DEG_W-1:0] d);
    lane_t          l;
    logic [DEG_W-1:0] idx;
    l = '0;
    if (d < DEG_QUARTER) begin
      idx = d;
    end else if (d < DEG_HALF) begin
      idx = DEG_HALF - d;
    end else if (d < DEG_THREE_QUARTER) begin
      idx = d - DEG_HALF;
      l.neg = 1'b1;
    end else begin
      idx = DEG_FULL - d;
      l.neg = 1'b1;
    end
    l.deg_addr = idx[DEG_AW-1:0];
    return l;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rsg_if.sv
`default_nettype none

interface rsg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] angle_value;

  modport source (output valid, output req_type, output angle_value, input ready);
  modport sink (input valid, input req_type, input angle_value, output ready);
endinterface

interface rsg_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] sin_dac;
  logic [11:0] cos_dac;

  modport source (output valid, output sin_dac, output cos_dac, input ready);
  modport sink (input valid, input sin_dac, input cos_dac, output ready);
endinterface

interface rsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] velocity;

  modport source (output valid, output velocity, input ready);
  modport sink (input valid, input velocity, output ready);
endinterface

`default_nettype wire

// File: hdl/resolver_sin_cos_generator_core.sv
// A result word passes the stage-one and table-read registers, then the output register.
// Throughput: one request word per cycle while the output does not stall, set by the
// angle accumulator and the registered two-address table read that follows it.
// Requests that produce no result are still accepted from the input channel.
// Reset clears the shaft angle, the velocity register and all pipeline valid flags.
`default_nettype none

module resolver_sin_cos_generator_core (
  input  wire logic clk,
  input  wire logic rst,
  rsg_req_if.sink   req,
  rsg_cfg_if.sink   cfg,
  rsg_res_if.source res
);
  import rsg_pkg::*;

  look_t     look;
  rom_word_t sin_rd;
  rom_word_t cos_rd;
  logic      load_en;
  logic      accept;

  assign req.ready = load_en;
  assign accept = req.valid && load_en;
  assign cfg.ready = 1'b1;

  rsg_angle u_angle (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (req.req_type),
    .angle_value  (req.angle_value),
    .cfg_we       (cfg.valid),
    .cfg_velocity (cfg.velocity),
    .look         (look)
  );

  rsg_rom u_rom (
    .clk    (clk),
    .en     (load_en),
    .look   (look),
    .sin_rd (sin_rd),
    .cos_rd (cos_rd)
  );

  rsg_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .look      (look),
    .sin_rd    (sin_rd),
    .cos_rd    (cos_rd),
    .load_en   (load_en),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sin_dac   (res.sin_dac),
    .cos_dac   (res.cos_dac)
  );

endmodule

`default_nettype wire

// File: hdl/rsg_angle.sv
`default_nettype none

module rsg_angle (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [1:0]                  req_type,
  input  wire logic [15:0]                 angle_value,
  input  wire logic                        cfg_we,
  input  wire logic [15:0]                 cfg_velocity,
  output rsg_pkg::look_t                   look
);
  import rsg_pkg::*;

  logic [ANGLE_W-1:0] shaft_angle;
  logic [ANGLE_W-1:0] shaft_angle_next;
  logic [ANGLE_W-1:0] velocity;
  logic               update;
  logic [DEG_W-1:0]   deg_sin;
  logic [DEG_W:0]     deg_sum;
  logic [DEG_W-1:0]   deg_cos;

  always_comb begin
    shaft_angle_next = shaft_angle;
    update = 1'b0;
    look = '0;
    deg_sin = angle_value[DEG_W-1:0];
    deg_sum = {1'b0, deg_sin} + {1'b0, DEG_QUARTER};
    deg_cos = (deg_sum > {1'b0, DEG_FULL}) ? DEG_W'(deg_sum - {1'b0, DEG_FULL})
                                           : deg_sum[DEG_W-1:0];
    unique case (req_code_t'(req_type))
      REQ_TICK: begin
        shaft_angle_next = shaft_angle + velocity;
        update = (velocity != '0);
        look.emit = update;
      end
      REQ_LOAD: begin
        shaft_angle_next = angle_value;
        update = 1'b1;
        look.emit = 1'b1;
      end
      REQ_DEGREE: begin
        look.emit = (angle_value <= DEG_LIMIT);
        look.deg_mode = 1'b1;
      end
      default: begin
        look.emit = 1'b0;
      end
    endcase
    if (look.deg_mode) begin
      look.sin_lane = degree_lane(deg_sin);
      look.cos_lane = degree_lane(deg_cos);
    end else begin
      look.sin_lane = quarter_lane(shaft_angle_next);
      look.cos_lane = quarter_lane(shaft_angle_next + COS_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shaft_angle <= '0;
      velocity <= '0;
    end else begin
      if (accept && update) begin
        shaft_angle <= shaft_angle_next;
      end
      if (cfg_we) begin
        velocity <= cfg_velocity;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/rsg_rom.sv
`default_nettype none

module rsg_rom (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire rsg_pkg::look_t look,
  output rsg_pkg::rom_word_t sin_rd,
  output rsg_pkg::rom_word_t cos_rd
);
  import rsg_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_rd.even <= QUARTER_EVEN[look.sin_lane.even_addr];
      sin_rd.odd <= QUARTER_ODD[look.sin_lane.odd_addr];
      sin_rd.deg <= DEGREE_TBL[look.sin_lane.deg_addr];
      cos_rd.even <= QUARTER_EVEN[look.cos_lane.even_addr];
      cos_rd.odd <= QUARTER_ODD[look.cos_lane.odd_addr];
      cos_rd.deg <= DEGREE_TBL[look.cos_lane.deg_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/rsg_out.sv
`default_nettype none

module rsg_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire rsg_pkg::look_t     look,
  input  wire rsg_pkg::rom_word_t sin_rd,
  input  wire rsg_pkg::rom_word_t cos_rd,
  output logic                    load_en,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [11:0]             sin_dac,
  output logic [11:0]             cos_dac
);
  import rsg_pkg::*;

  logic  s1_valid;
  logic  s1_deg_mode;
  lane_t s1_sin;
  lane_t s1_cos;
  logic  out_en;
  logic [DAC_W-1:0] sin_word;
  logic [DAC_W-1:0] cos_word;

  function automatic logic [DAC_W-1:0] dac_word(logic deg_mode, lane_t l, rom_word_t rd);
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [16:0]      prod;
    logic [MAG_W-1:0] mag;
    if (deg_mode) begin
      a = rd.deg;
      b = rd.deg;
    end else if (l.swap) begin
      a = rd.odd;
      b = rd.even;
    end else begin
      a = rd.even;
      b = rd.odd;
    end
    prod = 17'(b - a) * 17'(l.frac);
    mag = a + prod[16:6];
    return l.neg ? (DAC_MID + {1'b0, mag}) : (DAC_MID - {1'b0, mag});
  endfunction

  assign out_en = !out_valid || out_ready;
  assign load_en = !s1_valid || out_en;
  assign sin_word = dac_word(s1_deg_mode, s1_sin, sin_rd);
  assign cos_word = dac_word(s1_deg_mode, s1_cos, cos_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_en) begin
        s1_valid <= accept && look.emit;
      end
      if (out_en) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      s1_deg_mode <= look.deg_mode;
      s1_sin <= look.sin_lane;
      s1_cos <= look.cos_lane;
    end
    if (out_en) begin
      sin_dac <= sin_word;
      cos_dac <= cos_word;
    end
  end

endmodule

`default_nettype wire
